// ===== hw/rtl/fudu_pkg.sv =====
// Package for the file URI path decoder: payload types, character codes and decode helpers.
`default_nettype none
package fudu_pkg;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int NBYTES   = 4;
    localparam int BIDX_W   = $clog2(NBYTES);
    localparam int NCNT_W   = $clog2(NBYTES + 1);
    localparam int PREFIX_N = 7;

    localparam logic REG_WINDOWS_MODE = 1'b0;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       out_error;
    } res_word_t;

    // path bytes plus optional end-of-URI word produced by one input word
    typedef struct packed {
        logic [NBYTES-1:0][7:0] by;
        logic [NCNT_W-1:0]      n;
        logic                   fin;
        logic                   err;
    } bundle_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       decided;
    } hold_t;

    typedef struct packed {
        logic [NBYTES-1:0][7:0] by;
        logic [NCNT_W-1:0]      n;
    } ob_t;

    typedef struct packed {
        hold_t h;
        ob_t   o;
    } pp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] v;
    } hex_t;

    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_FIRST  = 7'b0000010,
        PH_BODY   = 7'b0000100,
        PH_ESC1   = 7'b0001000,
        PH_ESC2   = 7'b0010000,
        PH_DROP   = 7'b0100000,
        PH_FAIL   = 7'b1000000
    } phase_t;

    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = CH_COLON;
            3'd5:    c = CH_SLASH;
            3'd6:    c = CH_SLASH;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t r;
        r.ok = 1'b1;
        if (c >= 8'h30 && c <= 8'h39)
            r.v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            r.v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            r.v = 4'(c - 8'h37);
        else
        begin
            r.ok = 1'b0;
            r.v  = 4'd0;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic ob_t append(input ob_t o, input logic [7:0] b);
        ob_t r;
        r = o;
        r.by[o.n[BIDX_W-1:0]] = b;
        r.n = o.n + NCNT_W'(1);
        return r;
    endfunction

    function automatic ob_t flush(input hold_t h, input ob_t o);
        ob_t r;
        r = o;
        if (h.cnt >= 2'd1)
            r = append(r, h.b0);
        if (h.cnt >= 2'd2)
            r = append(r, h.b1);
        if (h.cnt == 2'd3)
            r = append(r, h.b2);
        return r;
    endfunction

    function automatic pp_t push_path(input hold_t hs, input ob_t ob,
                                      input logic [7:0] b_in, input logic wm);
        pp_t        r;
        logic [7:0] b;
        logic       take;
        r.h  = hs;
        r.o  = ob;
        b    = b_in;
        take = 1'b0;
        if (wm && b == CH_SLASH)
            b = CH_BSLASH;
        if (!wm || hs.decided)
        begin
            r.o     = flush(hs, r.o);
            r.h.cnt = 2'd0;
            r.o     = append(r.o, b);
        end
        else
        begin
            case (hs.cnt)
                2'd0:
                begin
                    if (b == CH_BSLASH)
                    begin
                        r.h.b0  = b;
                        r.h.cnt = 2'd1;
                        take    = 1'b1;
                    end
                end
                2'd1:
                begin
                    if (is_letter(b))
                    begin
                        r.h.b1  = b;
                        r.h.cnt = 2'd2;
                        take    = 1'b1;
                    end
                end
                2'd2:
                begin
                    if (b == CH_COLON)
                    begin
                        r.h.b2  = b;
                        r.h.cnt = 2'd3;
                        take    = 1'b1;
                    end
                end
                default:
                begin
                    if (b == CH_BSLASH)
                    begin
                        r.o     = append(append(r.o, hs.b1), hs.b2);
                        r.h.cnt = 2'd0;
                    end
                end
            endcase
            if (!take)
            begin
                r.o         = flush(r.h, r.o);
                r.h.cnt     = 2'd0;
                r.o         = append(r.o, b);
                r.h.decided = 1'b1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/file_uri_path_decoder_unit.sv =====
// Top level of the file URI path decoder: config register, front end, queue and back end.
//
// Input channel in_valid/in_ready/in_word carries one URI byte per word, with in_last on
// the final byte. Result channel res_valid/res_ready/res_word carries decoded path bytes
// (out_valid=1) and one closing word per URI (out_last=1, out_error flags a failed parse;
// on failure the receiver drops the path bytes already taken for that URI).
// Register windows_mode sits at APB address 0; write it only while the block is idle.
// A result word is registered in the bundle queue and then in the output register.
// Throughput: one input word per cycle while the four-entry bundle queue has room; the
// output side drains one result word per cycle while res_ready is high, so an input
// word that expands to up to five result words holds the output longer; the queue absorbs it.
// When the receiver stalls, the output word is held, the queue fills and in_ready drops.
// Reset clears the parse phase, hold state, queue pointers, output valid and windows_mode.
`default_nettype none
module file_uri_path_decoder_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fudu_pkg::PADDR_W-1:0]  paddr,
    input  wire [fudu_pkg::PDATA_W-1:0]  pwdata,
    output logic [fudu_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire fudu_pkg::in_word_t      in_word,
    output logic                         res_valid,
    input  wire                          res_ready,
    output fudu_pkg::res_word_t          res_word
);
    import fudu_pkg::*;

    logic    wm_reg;
    logic    q_push, q_pop, q_full, q_empty;
    bundle_t q_wdata, q_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOWS_MODE) ? {{(PDATA_W-1){1'b0}}, wm_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wm_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOWS_MODE)
            wm_reg <= pwdata[0];
    end

    fudu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wm       (wm_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    fudu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    fudu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    a_close_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_last |-> !res_word.out_valid && res_word.out_byte == 8'h00)
        else $error("closing word carries a path byte");

    a_err_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_error |-> res_word.out_last)
        else $error("error flag on a path word");

    a_bundle_size: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_wdata.n <= NCNT_W'(NBYTES))
        else $error("bundle holds too many path bytes");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== hw/rtl/fudu_front.sv =====
// Front end: accepts URI words, tracks parse state and builds at most one output bundle per word.
`default_nettype none
module fudu_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               wm,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire fudu_pkg::in_word_t in_word,
    input  wire               q_full,
    output logic              q_push,
    output fudu_pkg::bundle_t q_data
);
    import fudu_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic [3:0] esc_reg, esc_next;
    hold_t      hold_reg, hold_next;

    logic       accept;
    logic [7:0] b;
    hex_t       hx;
    pp_t        pp;
    logic       err;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_word.in_byte;
    assign hx       = hex_value(b);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        esc_next   = esc_reg;
        pp.h       = hold_reg;
        pp.o       = '0;
        err        = 1'b0;
        case (phase_reg)
            PH_PREFIX:
            begin
                if (pos_reg != 3'(PREFIX_N) && b == scheme_char(pos_reg))
                begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'(PREFIX_N - 1))
                        phase_next = PH_FIRST;
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_FIRST, PH_BODY:
            begin
                phase_next = PH_BODY;
                if (phase_reg == PH_FIRST && b != CH_SLASH)
                begin
                    pp = push_path(pp.h, pp.o, CH_SLASH, wm);
                    pp = push_path(pp.h, pp.o, CH_SLASH, wm);
                end
                if (b == CH_QUEST || b == CH_HASH)
                    phase_next = PH_DROP;
                else if (b == CH_PCT)
                    phase_next = PH_ESC1;
                else
                    pp = push_path(pp.h, pp.o, b, wm);
            end
            PH_ESC1:
            begin
                if (hx.ok)
                begin
                    esc_next   = hx.v;
                    phase_next = PH_ESC2;
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_ESC2:
            begin
                if (hx.ok)
                begin
                    phase_next = PH_BODY;
                    pp = push_path(pp.h, pp.o, {esc_reg, hx.v}, wm);
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_DROP:
            begin
            end
            default:
                phase_next = PH_FAIL;
        endcase
        if (in_word.in_last)
        begin
            err = !(phase_next == PH_BODY || phase_next == PH_DROP);
            if (!err)
            begin
                if (pp.h.cnt == 2'd3 && wm && !pp.h.decided)
                    pp.o = append(append(pp.o, pp.h.b1), pp.h.b2);
                else
                    pp.o = flush(pp.h, pp.o);
            end
            phase_next     = PH_PREFIX;
            pos_next       = 3'd0;
            pp.h.cnt       = 2'd0;
            pp.h.decided   = 1'b0;
        end
        hold_next = pp.h;
    end

    assign q_data.by  = pp.o.by;
    assign q_data.n   = pp.o.n;
    assign q_data.fin = in_word.in_last;
    assign q_data.err = err;
    assign q_push     = accept && (pp.o.n != '0 || in_word.in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= 3'd0;
            hold_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            esc_reg <= esc_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fudu_queue.sv =====
// Bundle queue between the front end and the output sequencer.
`default_nettype none
module fudu_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire fudu_pkg::bundle_t wdata,
    input  wire               pop,
    output fudu_pkg::bundle_t rdata,
    output logic              full,
    output logic              empty
);
    import fudu_pkg::*;

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wp_reg, rp_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full  = cnt_reg == QCNT_W'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + QPTR_W'(1);
            if (pop)
                rp_reg <= rp_reg + QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fudu_back.sv =====
// Back end: walks each bundle, one result word per cycle unless stalled, into the output register.
`default_nettype none
module fudu_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire fudu_pkg::bundle_t head,
    input  wire                 q_empty,
    output logic                q_pop,
    output logic                res_valid,
    input  wire                 res_ready,
    output fudu_pkg::res_word_t res_word
);
    import fudu_pkg::*;

    logic [NCNT_W-1:0] k_reg, k_next;
    logic              ov_reg;
    res_word_t         ow_reg, ow_next;
    logic              load, last_word;

    assign load      = (!ov_reg || res_ready) && !q_empty;
    assign last_word = head.fin ? (k_reg == head.n) : (k_reg + NCNT_W'(1) == head.n);
    assign q_pop     = load && last_word;
    assign k_next    = last_word ? '0 : k_reg + NCNT_W'(1);

    always_comb
    begin
        if (k_reg < head.n)
        begin
            ow_next.out_byte  = head.by[k_reg[BIDX_W-1:0]];
            ow_next.out_valid = 1'b1;
            ow_next.out_last  = 1'b0;
            ow_next.out_error = 1'b0;
        end
        else
        begin
            ow_next.out_byte  = 8'h00;
            ow_next.out_valid = 1'b0;
            ow_next.out_last  = 1'b1;
            ow_next.out_error = head.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                k_reg  <= k_next;
                ov_reg <= 1'b1;
            end
            else if (res_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ow_reg <= ow_next;
    end

    assign res_valid = ov_reg;
    assign res_word  = ow_reg;

endmodule
`default_nettype wire
